/* rtl/cflm_pkg.sv */
// Package for the chunk free-list manager.
// Holds field widths, command codes, reset constants and the result record.
// No dependencies.
package cflm_pkg;

  localparam int CMD_W   = 3;
  localparam int CHUNK_W = 8;
  localparam int LEN_W   = 9;
  localparam int POOL_W  = 9;

  localparam int MAX_CHUNKS_DEF = 256;
  localparam int POOL_RESET     = 256;

  localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ORDERED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RUN     = 3'd4;

  localparam logic REG_POOL_CHUNKS = 1'b0;

  typedef struct packed {
    logic [CHUNK_W-1:0] granted_chunk;
    logic               granted;
    logic               list_empty;
  } result_t;

endpackage

/* rtl/cflm_link_ram.sv */
// Next-link store of the chunk free-list manager.
// One write port, one read port with registered read data; no reset.
// Depends on nothing.
module cflm_link_ram #(
  parameter int DEPTH = 256,
  parameter int LW    = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [LW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [LW-1:0]            rdata
);

  logic [LW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cflm_step_unit.sv */
// Shared step unit of the chunk free-list manager: one incrementer and one
// less-than compare, reused by every walk and sweep. No dependencies.
module cflm_step_unit #(
  parameter int LW = 9
) (
  input  logic [LW-1:0] a,
  input  logic [LW-1:0] x,
  input  logic [LW-1:0] y,
  input  logic          cmp_inc,
  output logic [LW-1:0] inc,
  output logic          lt
);

  logic [LW-1:0] xs;

  assign inc = a + LW'(1);
  assign xs  = cmp_inc ? inc : x;
  assign lt  = xs < y;

endmodule

/* rtl/cflm_seq.sv */
// Command sequencer of the chunk free-list manager: head register, walk
// pointers and the state machine that drives the link store and step unit.
// Depends on cflm_pkg, cflm_link_ram and cflm_step_unit.
module cflm_seq
  import cflm_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [CHUNK_W-1:0] chunk,
  input  logic [LEN_W-1:0]   run_length,
  input  logic [POOL_W-1:0]  pool_chunks,
  output logic               res_valid,
  output result_t            res,
  input  logic               res_take
);

  localparam int LW = $clog2(MAX_CHUNKS + 1);
  localparam int IW = $clog2(MAX_CHUNKS);
  localparam int CW = (LW > CHUNK_W) ? LW : CHUNK_W;
  localparam int RW = ((LW > LEN_W) ? LW : LEN_W) + 1;
  localparam int RST_LIM = (POOL_RESET > MAX_CHUNKS) ? MAX_CHUNKS : POOL_RESET;
  localparam logic [LW-1:0] NIL  = LW'(MAX_CHUNKS);
  localparam logic [LW-1:0] LAST = LW'(MAX_CHUNKS - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_ALLOC_RD = 4'd2;
  localparam logic [3:0] S_ALLOC_WB = 4'd3;
  localparam logic [3:0] S_ORD_RD   = 4'd4;
  localparam logic [3:0] S_ORD_CMP  = 4'd5;
  localparam logic [3:0] S_ORD_LINK = 4'd6;
  localparam logic [3:0] S_RUN_SET  = 4'd7;
  localparam logic [3:0] S_RUN_WR   = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]       state, state_next;
  logic [LW-1:0]    head, head_next;
  logic [LW-1:0]    ptr, ptr_next;
  logic [LW-1:0]    lim, lim_next;
  logic             pend, pend_next;
  logic [LW-1:0]    steps, steps_next;
  logic [LW-1:0]    c_reg, c_reg_next;
  logic [LEN_W-1:0] len_reg, len_reg_next;
  logic             s_lt_c, s_lt_c_next;
  logic [LW-1:0]    gnt_chunk, gnt_chunk_next;
  logic             gnt, gnt_next;

  logic          we;
  logic [LW-1:0] wa, wd, ra;
  logic [LW-1:0] rdata;
  logic [LW-1:0] u_a, u_x, u_y, u_inc;
  logic          u_cmp_inc, u_lt;

  logic [CW-1:0] c_cw;
  logic          c_ok;
  logic [LW-1:0] c_ext;
  logic [RW-1:0] pool_rw, rem, len_rw;
  logic [CW-1:0] g_cw;
  logic          accept;

  assign c_cw    = CW'(chunk);
  assign c_ok    = c_cw < CW'(MAX_CHUNKS);
  assign c_ext   = c_cw[LW-1:0];
  assign pool_rw = RW'(pool_chunks);
  assign rem     = RW'(MAX_CHUNKS) - RW'(c_reg);
  assign len_rw  = RW'(len_reg);
  assign accept  = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  cflm_link_ram #(.DEPTH(MAX_CHUNKS), .LW(LW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wa[IW-1:0]),
    .wdata (wd),
    .raddr (ra[IW-1:0]),
    .rdata (rdata)
  );

  cflm_step_unit #(.LW(LW)) u_step (
    .a       (u_a),
    .x       (u_x),
    .y       (u_y),
    .cmp_inc (u_cmp_inc),
    .inc     (u_inc),
    .lt      (u_lt)
  );

  always_comb begin
    state_next     = state;
    head_next      = head;
    ptr_next       = ptr;
    lim_next       = lim;
    pend_next      = pend;
    steps_next     = steps;
    c_reg_next     = c_reg;
    len_reg_next   = len_reg;
    s_lt_c_next    = s_lt_c;
    gnt_chunk_next = gnt_chunk;
    gnt_next       = gnt;
    we        = 1'b0;
    wa        = ptr;
    wd        = head;
    ra        = ptr;
    u_a       = ptr;
    u_x       = ptr;
    u_y       = lim;
    u_cmp_inc = 1'b0;
    res_valid = 1'b0;

    case (state)
      S_IDLE: begin
        u_x = c_ext;
        u_y = head;
        if (accept) begin
          pend_next      = 1'b1;
          gnt_next       = 1'b0;
          gnt_chunk_next = '0;
          c_reg_next     = c_ext;
          len_reg_next   = run_length;
          state_next     = S_DONE;
          case (command)
            CMD_INIT: begin
              ptr_next   = '0;
              lim_next   = (pool_rw > RW'(MAX_CHUNKS)) ? NIL : LW'(pool_rw);
              head_next  = (pool_chunks == '0) ? NIL : '0;
              state_next = S_INIT;
            end
            CMD_ALLOC: begin
              if (head != NIL) begin
                state_next = S_ALLOC_RD;
              end
            end
            CMD_RELEASE: begin
              if (c_ok) begin
                we        = 1'b1;
                wa        = c_ext;
                wd        = head;
                head_next = c_ext;
              end
            end
            CMD_ORDERED: begin
              if (c_ok) begin
                if (head == NIL || u_lt) begin
                  // empty list or below the head: push at the head
                  we        = 1'b1;
                  wa        = c_ext;
                  wd        = head;
                  head_next = c_ext;
                end else begin
                  ptr_next   = head;
                  steps_next = '0;
                  state_next = S_ORD_RD;
                end
              end
            end
            CMD_RUN: begin
              if (c_ok && run_length != '0) begin
                state_next = S_RUN_SET;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INIT: begin
        // chain ptr to ptr+1 while ptr+1 stays inside the pool
        u_cmp_inc = 1'b1;
        we        = 1'b1;
        wa        = ptr;
        wd        = u_lt ? u_inc : NIL;
        ptr_next  = u_inc;
        if (ptr == LAST) begin
          state_next = pend ? S_DONE : S_IDLE;
        end
      end

      S_ALLOC_RD: begin
        ra         = head;
        state_next = S_ALLOC_WB;
      end

      S_ALLOC_WB: begin
        gnt_next       = 1'b1;
        gnt_chunk_next = head;
        head_next      = rdata;
        state_next     = S_DONE;
      end

      S_ORD_RD: begin
        ra          = ptr;
        u_x         = ptr;
        u_y         = c_reg;
        s_lt_c_next = u_lt;
        state_next  = S_ORD_CMP;
      end

      S_ORD_CMP: begin
        u_a = steps;
        u_x = c_reg;
        u_y = rdata;
        if (s_lt_c && (rdata == NIL || u_lt)) begin
          we         = 1'b1;
          wa         = c_reg;
          wd         = rdata;
          state_next = S_ORD_LINK;
        end else begin
          ptr_next   = rdata;
          steps_next = u_inc;
          // drop the chunk at the end of the list or at the walk bound
          if (rdata == NIL || steps == LAST) begin
            state_next = S_DONE;
          end else begin
            state_next = S_ORD_RD;
          end
        end
      end

      S_ORD_LINK: begin
        we         = 1'b1;
        wa         = ptr;
        wd         = c_reg;
        state_next = S_DONE;
      end

      S_RUN_SET: begin
        ptr_next = c_reg;
        if (len_rw > rem) begin
          lim_next = LAST;
        end else begin
          lim_next = LW'(RW'(c_reg) + len_rw - RW'(1));
        end
        state_next = S_RUN_WR;
      end

      S_RUN_WR: begin
        we = 1'b1;
        wa = ptr;
        if (u_lt) begin
          wd       = u_inc;
          ptr_next = u_inc;
        end else begin
          wd         = head;
          head_next  = c_reg;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          pend_next  = 1'b0;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign g_cw              = CW'(gnt_chunk);
  assign res.granted_chunk = g_cw[CHUNK_W-1:0];
  assign res.granted       = gnt;
  assign res.list_empty    = (head == NIL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      head  <= (RST_LIM == 0) ? NIL : '0;
      ptr   <= '0;
      lim   <= LW'(RST_LIM);
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      ptr   <= ptr_next;
      lim   <= lim_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    steps     <= steps_next;
    c_reg     <= c_reg_next;
    len_reg   <= len_reg_next;
    s_lt_c    <= s_lt_c_next;
    gnt_chunk <= gnt_chunk_next;
    gnt       <= gnt_next;
  end

  a_res_owed: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pend)
    else $error("result offered with no item owed");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (wa < NIL))
    else $error("link write outside the pool");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN_WR) |-> (ptr <= lim && lim < NIL))
    else $error("run write past its last chunk");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ORD_RD) |-> (ptr != NIL && steps < NIL))
    else $error("ordered walk beyond its bound");

  a_grant_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC_RD) |=> (state == S_ALLOC_WB && $stable(head) && head != NIL))
    else $error("allocate read lost the head");

endmodule

/* rtl/chunk_free_list_manager.sv */
// Top level of the chunk free-list manager.
// Holds the pool_chunks register, its APB-style port and the output register.
// Depends on cflm_pkg and cflm_seq.
//
// Chunks 0..MAX_CHUNKS-1 are kept on a singly linked free list: a head
// register plus a next-link memory of MAX_CHUNKS entries, handled by one
// sequencer and a shared increment/compare unit, one item at a time.
// Release, a failed allocate and unknown commands go straight to the
// result; a successful allocate does one registered memory read;
// initialize writes one link per cycle across the whole memory; a release
// run writes one link per chunk; an ordered release reads and compares each
// link visited, up to MAX_CHUNKS links. in_stall stays high from accept
// until the result has moved into the output register, which frees the
// input while that result waits for the receiver. After reset the
// sequencer sweeps the link memory to build the initial list, with
// in_stall high during the sweep; configuration writes are taken throughout.
module chunk_free_list_manager
  import cflm_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   command,
  input  logic [CHUNK_W-1:0] chunk,
  input  logic [LEN_W-1:0]   run_length,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHUNK_W-1:0] granted_chunk,
  output logic               granted,
  output logic               list_empty,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [POOL_W-1:0] pool_chunks;
  logic              res_valid;
  logic              res_take;
  result_t           res;
  logic              reg_hit;

  // register index is the word address; one register is implemented
  assign reg_hit = (paddr[2] == REG_POOL_CHUNKS);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? 32'(pool_chunks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_chunks <= POOL_W'(POOL_RESET);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      pool_chunks <= pwdata[POOL_W-1:0];
    end
  end

  cflm_seq #(.MAX_CHUNKS(MAX_CHUNKS)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .chunk       (chunk),
    .run_length  (run_length),
    .pool_chunks (pool_chunks),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  // take a new result whenever the output register is empty or draining
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  // hold the payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      granted_chunk <= res.granted_chunk;
      granted       <= res.granted;
      list_empty    <= res.list_empty;
    end
  end

endmodule
